[hw/rtl/tpa_pkg.sv]
// Shared constants for the tree pseudo-LRU fully associative cache.
`timescale 1ns / 1ps

package tpa_pkg;

  // Default number of ways.
  localparam int unsigned DEFAULT_WAYS = 16;

  // Fixed field widths at the ports.
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WAY_IDX_W = 6;

endpackage

[hw/rtl/tpa_plru_tree.sv]
// Hot/cold bit tree: cold-side victim walk and hot-path update.
`timescale 1ns / 1ps

module tpa_plru_tree #(
  parameter int unsigned WAYS = tpa_pkg::DEFAULT_WAYS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      upd_en_i,
  input  logic [$clog2(WAYS)-1:0]   upd_way_i,
  output logic [$clog2(WAYS)-1:0]   victim_way_o
);

  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned NODE_W = $clog2(2 * WAYS - 1);
  localparam int unsigned IDX_W  = (WAYS > 2) ? $clog2(WAYS - 1) : 1;
  localparam int unsigned DEPTH  = $clog2(WAYS) + 1;
  localparam int unsigned NINT   = WAYS - 1;

  logic [NINT-1:0] plru_q, plru_d;
  logic [NINT-1:0] path_mask;
  logic [NINT-1:0] path_val;
  logic [NODE_W-1:0] walk_node;
  logic [NODE_W-1:0] up_node;
  logic [NODE_W-1:0] up_parent;

  // Follow the cold side from the root: bit 0 takes the right child.
  always_comb begin
    walk_node = '0;
    for (int s = 0; s < DEPTH; s++) begin
      if (walk_node < NODE_W'(NINT)) begin
        if (plru_q[walk_node[IDX_W-1:0]]) begin
          walk_node = (walk_node << 1) + NODE_W'(1);
        end else begin
          walk_node = (walk_node << 1) + NODE_W'(2);
        end
      end
    end
    victim_way_o = WAY_W'(walk_node - NODE_W'(NINT));
  end

  // Climb from the leaf and point each node on the path away from it.
  always_comb begin
    path_mask = '0;
    path_val  = '0;
    up_node   = NODE_W'(upd_way_i) + NODE_W'(NINT);
    up_parent = '0;
    for (int s = 0; s < DEPTH; s++) begin
      if (up_node != '0) begin
        if (!up_node[0]) begin
          up_parent = (up_node - NODE_W'(2)) >> 1;
          path_val[up_parent[IDX_W-1:0]] = 1'b1;
        end else begin
          up_parent = (up_node - NODE_W'(1)) >> 1;
          path_val[up_parent[IDX_W-1:0]] = 1'b0;
        end
        path_mask[up_parent[IDX_W-1:0]] = 1'b1;
        up_node = up_parent;
      end
    end
  end

  always_comb begin
    plru_d = plru_q;
    if (upd_en_i) begin
      plru_d = (plru_q & ~path_mask) | (path_val & path_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plru_q <= '0;
    end else begin
      plru_q <= plru_d;
    end
  end

endmodule

[hw/rtl/tree_plru_assoc_cache.sv]
// Top level of the tree pseudo-LRU fully associative cache.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   block_address_i (32 bits)
// out      output     out_valid_o / out_stall_i hit_o, way_index_o (1 + 6 bits)
//
// One transaction a cycle when out_stall_i is low: a lookup sits in the input
// register while the tag compare, victim walk and tree update run on it, and
// moves into the result register once that register is free or drains; the
// result register then offers it.
// Reset clears valid bits, tree bits and both handshake flags; tags stay as
// they are. A stall on the output holds the result and then holds the input
// register, and stall propagates back to in_stall_o in the same cycle.

module tree_plru_assoc_cache #(
  parameter int unsigned WAYS = tpa_pkg::DEFAULT_WAYS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tpa_pkg::ADDR_W-1:0]    block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [tpa_pkg::WAY_IDX_W-1:0] way_index_o
);

  localparam int unsigned WAY_W = $clog2(WAYS);

  // Input register.
  logic                       in_valid_q, in_valid_d;
  logic [tpa_pkg::ADDR_W-1:0] addr_q;

  // Tag store (no reset) and entry valid bits.
  logic [tpa_pkg::ADDR_W-1:0] tag_q [WAYS];
  logic [WAYS-1:0]            valid_q, valid_d;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic                       hit_q;
  logic [WAY_W-1:0]           way_q;

  logic             advance;
  logic             process;
  logic             accept;
  logic             lookup_hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim_way;
  logic [WAY_W-1:0] sel_way;

  // Advance the input register when the result register is free or drains.
  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Compare every valid entry; the lowest matching way wins.
  always_comb begin
    lookup_hit = 1'b0;
    hit_way    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_q[w] && (tag_q[w] == addr_q)) begin
        lookup_hit = 1'b1;
        hit_way    = WAY_W'(w);
      end
    end
  end

  assign sel_way = lookup_hit ? hit_way : victim_way;

  tpa_plru_tree #(
    .WAYS(WAYS)
  ) u_plru (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_en_i     (process),
    .upd_way_i    (sel_way),
    .victim_way_o (victim_way)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
  end

  // Mark the victim valid on a miss.
  always_comb begin
    valid_d = valid_q;
    if (process && !lookup_hit) begin
      valid_d[sel_way] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (process) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on acceptance, fill tags on a miss.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= block_address_i;
    end
    if (process && !lookup_hit) begin
      tag_q[sel_way] <= addr_q;
    end
    if (process) begin
      hit_q <= lookup_hit;
      way_q <= sel_way;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_index_o = tpa_pkg::WAY_IDX_W'(way_q);

endmodule

[dv/tb_tree_plru_assoc_cache.sv]
// Self-checking testbench for the tree pseudo-LRU fully associative cache.
`timescale 1ns / 1ps

module tb_tree_plru_assoc_cache;

  localparam int unsigned WAYS           = tpa_pkg::DEFAULT_WAYS;
  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RANDOM_ITEMS   = 530;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT    = 50;

  // One lookup waiting to be driven; wait_idle makes the sender pause until
  // every result already owed by the block has come back.
  typedef struct {
    logic [tpa_pkg::ADDR_W-1:0] addr;
    bit                         wait_idle;
  } lookup_req_t;

  typedef struct packed {
    logic                          hit;
    logic [tpa_pkg::WAY_IDX_W-1:0] way;
  } lookup_result_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [tpa_pkg::ADDR_W-1:0]    block_address_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic                          hit_o;
  logic [tpa_pkg::WAY_IDX_W-1:0] way_index_o;

  tree_plru_assoc_cache #(
    .WAYS(WAYS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .block_address_i(block_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .way_index_o    (way_index_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Cache predictor: its own copy of tags, valid bits and hot/cold tree bits.
  // Tags are only ever compared once their valid bit is set, so the array
  // needs no reset value.
  // ---------------------------------------------------------------------------
  logic [tpa_pkg::ADDR_W-1:0] shadow_tags [WAYS];
  logic [WAYS-1:0]            shadow_valid = '0;
  logic [WAYS-2:0]            shadow_tree  = '0;

  lookup_req_t       pending_lookups [$];
  lookup_result_t    owed_results    [$];
  int unsigned       mismatches = 0;

  function automatic void predict_lookup(input logic [tpa_pkg::ADDR_W-1:0] addr,
                                         output lookup_result_t res);
    int unsigned node;
    int unsigned parent;
    int unsigned way;
    int unsigned i;
    bit          found;
    found = 1'b0;
    way   = 0;
    // Lowest valid matching way wins.
    for (i = 0; i < WAYS; i++) begin
      if (!found && shadow_valid[i] && shadow_tags[i] == addr) begin
        found = 1'b1;
        way   = i;
      end
    end
    // On a miss, walk the cold side from the root: 0 goes right, 1 goes left.
    // Validity plays no part in the walk.
    if (!found) begin
      node = 0;
      while (node < WAYS - 1) begin
        node = shadow_tree[node] ? 2 * node + 1 : 2 * node + 2;
      end
      way               = node - (WAYS - 1);
      shadow_tags[way]  = addr;
      shadow_valid[way] = 1'b1;
    end
    // Mark the path hot: point every node on it away from the used way.
    node = way + WAYS - 1;
    while (node != 0) begin
      if (node[0] == 1'b0) begin
        parent              = (node - 2) >> 1;
        shadow_tree[parent] = 1'b1;
      end else begin
        parent              = (node - 1) >> 1;
        shadow_tree[parent] = 1'b0;
      end
      node = parent;
    end
    res.hit = found;
    res.way = way[tpa_pkg::WAY_IDX_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
    mismatches++;
  endtask

  task automatic queue_lookup(input logic [tpa_pkg::ADDR_W-1:0] addr, input bit wait_idle);
    lookup_req_t req;
    req.addr      = addr;
    req.wait_idle = wait_idle;
    pending_lookups.push_back(req);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. Hold the payload while
  // the block stalls; predict each transaction at the edge that accepts it.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : driver
    logic                       offer;
    logic [tpa_pkg::ADDR_W-1:0] addr;
    lookup_result_t             want;
    if (rst_ni) begin
      offer = in_valid_i;
      addr  = block_address_i;
      if (in_valid_i && !in_stall_o) begin
        predict_lookup(block_address_i, want);
        owed_results.push_back(want);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_lookups.size() != 0 &&
                     !(pending_lookups[0].wait_idle && owed_results.size() != 0)) begin
          offer = 1'b1;
          addr  = pending_lookups[0].addr;
          void'(pending_lookups.pop_front());
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Start a new burst: mostly short ones, now and then a long
            // back-to-back run with no gap at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      // One nonblocking write per signal per edge: a valid that stays high
      // for the next transaction is never dropped and raised in the same step.
      in_valid_i      <= offer;
      block_address_i <= addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own whose density changes over time,
  // including stretches with no stall. Twice, after a given number of results,
  // hold off for a long stretch so that both pipeline registers fill and the
  // block stalls its input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  int unsigned results_taken = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_level   = 0;
  int unsigned level_left    = 0;

  always @(posedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_taken++;
        if (results_taken == 200 || results_taken == 420) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (level_left == 0) begin
        stall_level = $urandom_range(0, 3);
        level_left  = $urandom_range(16, 80);
      end else begin
        level_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) < stall_level);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with nothing owed", '0, 32'({hit_o, way_index_o}));
      end else begin
        want = owed_results.pop_front();
        if (hit_o !== want.hit) begin
          report_mismatch("hit", 32'(want.hit), 32'(hit_o));
        end
        if (way_index_o !== want.way) begin
          report_mismatch("way_index", 32'(want.way), 32'(way_index_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [tpa_pkg::ADDR_W-1:0] pool [$];
    logic [tpa_pkg::ADDR_W-1:0] addr;
    int unsigned                random_count;
    int unsigned                pool_size;
    int unsigned                phase_len;
    int unsigned                i;
    int unsigned                j;

    // Directed part: field extremes and their repeats as hits, single-bit and
    // alternating patterns, then enough distinct addresses to overflow the
    // ways so that the victim walk evicts valid entries, and a return to the
    // first address, which may or may not still be held.
    queue_lookup(32'h0000_0000, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b0);
    queue_lookup(32'h0000_0000, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b0);
    queue_lookup(32'h8000_0000, 1'b0);
    queue_lookup(32'h0000_0001, 1'b0);
    queue_lookup(32'hAAAA_AAAA, 1'b0);
    queue_lookup(32'h5555_5555, 1'b0);
    queue_lookup(32'h0000_0001, 1'b0);
    for (i = 1; i <= 12; i++) begin
      queue_lookup((i << 28) | i, 1'b0);
    end
    queue_lookup(32'h0000_0000, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b0);

    // Random part in phases. Each phase draws most addresses from a pool of
    // random tags, some a single bit away from another pool entry, so that
    // near misses reach the comparators. Pools no larger than the way count
    // give mostly hits; larger ones thrash the tree. The first lookup of each
    // phase waits until the block has drained.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(WAYS + 1, 2 * WAYS)
                                              : $urandom_range(2, WAYS);
      pool.delete();
      for (i = 0; i < pool_size; i++) begin
        if (i > 0 && $urandom_range(0, 2) == 0) begin
          pool.push_back(pool[$urandom_range(0, i - 1)] ^ (32'h1 << $urandom_range(0, 31)));
        end else begin
          pool.push_back($urandom());
        end
      end
      phase_len = $urandom_range(20, 60);
      for (j = 0; j < phase_len && random_count < RANDOM_ITEMS; j++) begin
        addr = ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, pool_size - 1)];
        queue_lookup(addr, j == 0);
        random_count++;
      end
    end

    // Reset once, then let the driver and receiver take over.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Check at the falling edge, once every process of the rising edge has
    // settled.
    while (pending_lookups.size() != 0 || in_valid_i || owed_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tpa_pkg.sv
hw/rtl/tpa_plru_tree.sv
hw/rtl/tree_plru_assoc_cache.sv
dv/tb_tree_plru_assoc_cache.sv
